@@ rtl/bdhs_pkg.sv @@
// Shared types and constants for the bisulfite directional hit scorer.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package bdhs_pkg;

   // Field widths of the request and response items
   localparam int COUNT_BITS_DEFAULT = 20;
   localparam int CMD_W   = 3;
   localparam int BASE_W  = 8;
   localparam int LEN_W   = 28;
   localparam int SCORE_W = 22;
   localparam int FIELD_W = 20;

   // Alignment event codes; codes above CMD_IGNORE behave like it
   typedef enum logic [CMD_W-1:0] {
      CMD_MATCH  = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_CLIP   = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_SKIP   = 3'd4,
      CMD_IGNORE = 3'd5
   } cmd_type;

   // Positions of the counters in the counter bank
   localparam int CNT_MATCH    = 0;
   localparam int CNT_EXPECT   = 1;
   localparam int CNT_WRONG    = 2;
   localparam int CNT_INDEL    = 3;
   localparam int CNT_CONV_A   = 4;
   localparam int CNT_CONV_B   = 5;
   localparam int CNT_UNCONV_A = 6;
   localparam int CNT_UNCONV_B = 7;
   localparam int CNT_SKIPPED  = 8;
   localparam int NUM_CNT      = 9;

   // ASCII base letters
   localparam logic [BASE_W-1:0] BASE_A = 8'h41;
   localparam logic [BASE_W-1:0] BASE_C = 8'h43;
   localparam logic [BASE_W-1:0] BASE_G = 8'h47;
   localparam logic [BASE_W-1:0] BASE_T = 8'h54;

endpackage

@@ rtl/bdhs_if.sv @@
// Request and response channel interfaces of the hit scorer.
// Depends on bdhs_pkg for the field widths.
`timescale 1ns / 1ps

interface bdhs_req_if;
   logic                             valid;
   logic                             ready;
   logic [bdhs_pkg::CMD_W-1:0]       cmd;
   logic [bdhs_pkg::BASE_W-1:0]      ref_base;
   logic [bdhs_pkg::BASE_W-1:0]      query_base;
   logic [bdhs_pkg::LEN_W-1:0]       run_length;
   logic                             last;

   modport source (output valid, cmd, ref_base, query_base, run_length, last,
                   input ready);
   modport sink   (input valid, cmd, ref_base, query_base, run_length, last,
                   output ready);
endinterface

interface bdhs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bdhs_pkg::SCORE_W-1:0] hit_score;
   logic [bdhs_pkg::FIELD_W-1:0]       bad_mismatches;
   logic [bdhs_pkg::FIELD_W-1:0]       conv_first;
   logic [bdhs_pkg::FIELD_W-1:0]       unconv_first;
   logic [bdhs_pkg::FIELD_W-1:0]       conv_second;
   logic [bdhs_pkg::FIELD_W-1:0]       unconv_second;
   logic [bdhs_pkg::FIELD_W-1:0]       wrong_count;
   logic [bdhs_pkg::FIELD_W-1:0]       noncounted_bases;

   modport source (output valid, hit_score, bad_mismatches, conv_first, unconv_first,
                   conv_second, unconv_second, wrong_count, noncounted_bases,
                   input ready);
   modport sink   (input valid, hit_score, bad_mismatches, conv_first, unconv_first,
                   conv_second, unconv_second, wrong_count, noncounted_bases,
                   output ready);
endinterface

@@ rtl/bdhs_accum.sv @@
// Input register, column classifier and saturating counter bank.
// Depends on bdhs_pkg and bdhs_req_if; hands a counter snapshot to bdhs_result.
`timescale 1ns / 1ps

module bdhs_accum #(
   parameter int COUNT_BITS = bdhs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   bdhs_req_if.sink            req_chan,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   output logic                snap_valid,
   input  logic                snap_take,
   output logic [bdhs_pkg::NUM_CNT-1:0][COUNT_BITS-1:0] snap_count
);

   localparam int LEN_W   = bdhs_pkg::LEN_W;
   localparam int NUM_CNT = bdhs_pkg::NUM_CNT;
   localparam int SUM_W   = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [LEN_W-1:0]      ONE     = LEN_W'(1);

   logic                              orient_ff;
   logic                              a_valid_ff;
   bdhs_pkg::cmd_type                 a_cmd_ff;
   logic [bdhs_pkg::BASE_W-1:0]       a_ref_ff;
   logic [bdhs_pkg::BASE_W-1:0]       a_qry_ff;
   logic [LEN_W-1:0]                  a_len_ff;
   logic                              a_last_ff;
   logic                              snap_valid_ff;
   logic [NUM_CNT-1:0][COUNT_BITS-1:0] count_ff;
   logic [NUM_CNT-1:0][COUNT_BITS-1:0] count_in;
   logic [NUM_CNT-1:0][COUNT_BITS-1:0] snap_count_ff;
   logic [NUM_CNT-1:0][LEN_W-1:0]     inc;
   logic                              snap_free;
   logic                              a_advance;
   logic                              req_accept;
   logic [bdhs_pkg::BASE_W-1:0]       unconv_first;
   logic [bdhs_pkg::BASE_W-1:0]       unconv_second;
   logic [bdhs_pkg::BASE_W-1:0]       yield_first;
   logic                              expected;

   // Advance the held request unless it closes a hit and the snapshot slot is busy
   assign snap_free      = !snap_valid_ff || snap_take;
   assign a_advance      = a_valid_ff && (!a_last_ff || snap_free);
   assign req_chan.ready = !a_valid_ff || a_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign snap_valid     = snap_valid_ff;
   assign snap_count     = snap_count_ff;

   // Pick the orientation-dependent letters
   always_comb begin
      unconv_first  = orient_ff ? bdhs_pkg::BASE_A : bdhs_pkg::BASE_T;
      unconv_second = orient_ff ? bdhs_pkg::BASE_C : bdhs_pkg::BASE_G;
      yield_first   = orient_ff ? bdhs_pkg::BASE_G : bdhs_pkg::BASE_A;
      if (orient_ff) begin
         expected = (a_ref_ff == bdhs_pkg::BASE_C && a_qry_ff == bdhs_pkg::BASE_T) ||
                    (a_ref_ff == bdhs_pkg::BASE_A && a_qry_ff == bdhs_pkg::BASE_G);
      end else begin
         expected = (a_ref_ff == bdhs_pkg::BASE_G && a_qry_ff == bdhs_pkg::BASE_A) ||
                    (a_ref_ff == bdhs_pkg::BASE_T && a_qry_ff == bdhs_pkg::BASE_C);
      end
   end

   // Classify the event into per-counter increments
   always_comb begin
      inc = '0;
      unique case (a_cmd_ff)
         bdhs_pkg::CMD_MATCH: begin
            if (a_ref_ff == a_qry_ff) begin
               inc[bdhs_pkg::CNT_MATCH] = ONE;
               if (a_qry_ff == unconv_first) begin
                  inc[bdhs_pkg::CNT_UNCONV_A] = ONE;
               end else if (a_qry_ff == unconv_second) begin
                  inc[bdhs_pkg::CNT_UNCONV_B] = ONE;
               end
            end else if (expected) begin
               inc[bdhs_pkg::CNT_EXPECT] = ONE;
               if (a_qry_ff == yield_first) begin
                  inc[bdhs_pkg::CNT_CONV_A] = ONE;
               end else begin
                  inc[bdhs_pkg::CNT_CONV_B] = ONE;
               end
            end else begin
               inc[bdhs_pkg::CNT_WRONG] = ONE;
            end
         end
         bdhs_pkg::CMD_INSERT, bdhs_pkg::CMD_DELETE: begin
            inc[bdhs_pkg::CNT_SKIPPED] = a_len_ff;
            inc[bdhs_pkg::CNT_INDEL]   = a_len_ff;
         end
         bdhs_pkg::CMD_CLIP: begin
            inc[bdhs_pkg::CNT_SKIPPED] = a_len_ff;
         end
         default: begin
         end
      endcase
   end

   // Saturating add, one per counter
   always_comb begin
      logic [SUM_W-1:0] sum;
      for (int k = 0; k < NUM_CNT; k++) begin
         sum = SUM_W'(count_ff[k]) + SUM_W'(inc[k]);
         count_in[k] = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_BITS-1:0];
      end
   end

   // Control state, orientation and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff     <= 1'b1;
         a_valid_ff    <= 1'b0;
         snap_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            orient_ff <= csr_wr_data;
         end
         if (req_accept) begin
            a_valid_ff <= 1'b1;
         end else if (a_advance) begin
            a_valid_ff <= 1'b0;
         end
         if (a_advance) begin
            count_ff <= a_last_ff ? '0 : count_in;
         end
         if (a_advance && a_last_ff) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_take) begin
            snap_valid_ff <= 1'b0;
         end
      end
   end

   // Hold request payload and the closing snapshot
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_cmd_ff  <= bdhs_pkg::cmd_type'(req_chan.cmd);
         a_ref_ff  <= req_chan.ref_base;
         a_qry_ff  <= req_chan.query_base;
         a_len_ff  <= req_chan.run_length;
         a_last_ff <= req_chan.last;
      end
      if (a_advance && a_last_ff) begin
         snap_count_ff <= count_in;
      end
   end

endmodule

@@ rtl/bdhs_result.sv @@
// Score formation, field clipping and the response register.
// Depends on bdhs_pkg and bdhs_rsp_if; takes snapshots from bdhs_accum.
`timescale 1ns / 1ps

module bdhs_result #(
   parameter int COUNT_BITS = bdhs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                snap_valid,
   output logic                snap_take,
   input  logic [bdhs_pkg::NUM_CNT-1:0][COUNT_BITS-1:0] snap_count,
   bdhs_rsp_if.source          rsp_chan
);

   localparam int SCORE_W = bdhs_pkg::SCORE_W;
   localparam int FIELD_W = bdhs_pkg::FIELD_W;
   localparam int SW = (COUNT_BITS + 3 > SCORE_W + 1) ? COUNT_BITS + 3 : SCORE_W + 1;
   localparam int CW = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
   localparam logic signed [SW-1:0] SMAX = SW'(2 ** (SCORE_W - 1) - 1);
   localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
   localparam logic [CW-1:0]        FIELD_MAX = CW'({FIELD_W{1'b1}});

   logic                      rsp_valid_ff;
   logic signed [SCORE_W-1:0] hit_score_ff;
   logic signed [SCORE_W-1:0] hit_score_in;
   logic [FIELD_W-1:0]        bad_ff;
   logic [FIELD_W-1:0]        conv_first_ff;
   logic [FIELD_W-1:0]        unconv_first_ff;
   logic [FIELD_W-1:0]        conv_second_ff;
   logic [FIELD_W-1:0]        unconv_second_ff;
   logic [FIELD_W-1:0]        noncounted_ff;
   logic signed [SW-1:0]      score_raw;

   function automatic logic signed [SW-1:0] widen(input logic [COUNT_BITS-1:0] v);
      widen = signed'(SW'(v));
   endfunction

   function automatic logic [FIELD_W-1:0] clip(input logic [COUNT_BITS-1:0] v);
      logic [CW-1:0] w;
      w    = CW'(v);
      clip = (w > FIELD_MAX) ? {FIELD_W{1'b1}} : w[FIELD_W-1:0];
   endfunction

   // Load a snapshot when the response register is empty or draining
   assign snap_take = snap_valid && (!rsp_valid_ff || rsp_chan.ready);

   // Form and clamp the score
   always_comb begin
      score_raw = widen(snap_count[bdhs_pkg::CNT_MATCH])
                + widen(snap_count[bdhs_pkg::CNT_EXPECT])
                - widen(snap_count[bdhs_pkg::CNT_WRONG])
                - widen(snap_count[bdhs_pkg::CNT_INDEL]);
      priority if (score_raw > SMAX) begin
         hit_score_in = SMAX[SCORE_W-1:0];
      end else if (score_raw < SMIN) begin
         hit_score_in = SMIN[SCORE_W-1:0];
      end else begin
         hit_score_in = score_raw[SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (snap_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Hold response payload
   always_ff @(posedge clock) begin
      if (snap_take) begin
         hit_score_ff     <= hit_score_in;
         bad_ff           <= clip(snap_count[bdhs_pkg::CNT_WRONG]);
         conv_first_ff    <= clip(snap_count[bdhs_pkg::CNT_CONV_A]);
         unconv_first_ff  <= clip(snap_count[bdhs_pkg::CNT_UNCONV_A]);
         conv_second_ff   <= clip(snap_count[bdhs_pkg::CNT_CONV_B]);
         unconv_second_ff <= clip(snap_count[bdhs_pkg::CNT_UNCONV_B]);
         noncounted_ff    <= clip(snap_count[bdhs_pkg::CNT_SKIPPED]);
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.hit_score        = hit_score_ff;
   assign rsp_chan.bad_mismatches   = bad_ff;
   assign rsp_chan.conv_first       = conv_first_ff;
   assign rsp_chan.unconv_first     = unconv_first_ff;
   assign rsp_chan.conv_second      = conv_second_ff;
   assign rsp_chan.unconv_second    = unconv_second_ff;
   assign rsp_chan.wrong_count      = bad_ff;
   assign rsp_chan.noncounted_bases = noncounted_ff;

endmodule

@@ rtl/bisulfite_directional_hit_scorer_top.sv @@
// A last request passes the input register, snapshot slot and response register.
// Throughput: one request per cycle while nothing stalls; input register, counter
// bank and response register each pass one item per cycle, snapshot slot between.
// Reset (synchronous): counters clear, channels empty, orientation_one set to 1.
// Depends on bdhs_pkg, bdhs_if, bdhs_accum and bdhs_result.
`timescale 1ns / 1ps

module bisulfite_directional_hit_scorer_top #(
   parameter int COUNT_BITS = bdhs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bdhs_req_if.sink   req_chan,
   bdhs_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic                                         snap_valid;
   logic                                         snap_take;
   logic [bdhs_pkg::NUM_CNT-1:0][COUNT_BITS-1:0] snap_count;

   // Accumulate events of the current hit
   bdhs_accum #(.COUNT_BITS(COUNT_BITS)) u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .snap_valid  (snap_valid),
      .snap_take   (snap_take),
      .snap_count  (snap_count)
   );

   // Turn a closed hit into a response
   bdhs_result #(.COUNT_BITS(COUNT_BITS)) u_result (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_take  (snap_take),
      .snap_count (snap_count),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ rtl/bdhs_checker.sv @@
// Port-level checks on the response channel of the hit scorer.
// Depends on bdhs_pkg; bound to bisulfite_directional_hit_scorer_top below.
`timescale 1ns / 1ps

module bdhs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [bdhs_pkg::SCORE_W-1:0] rsp_hit_score,
   input logic [bdhs_pkg::FIELD_W-1:0]       rsp_bad_mismatches,
   input logic [bdhs_pkg::FIELD_W-1:0]       rsp_wrong_count,
   input logic [bdhs_pkg::FIELD_W-1:0]       rsp_noncounted_bases
);

   // No response is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit_score) && $stable(rsp_bad_mismatches))
      else $error("response payload changed while stalled");

   // Both wrong-conversion fields come from the same counter
   a_wrong_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wrong_count == rsp_bad_mismatches)
      else $error("wrong_count differs from bad_mismatches");

   // Without wrong conversions and indels the score cannot go negative
   a_score_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_mismatches == '0 && rsp_noncounted_bases == '0
      |-> !rsp_hit_score[bdhs_pkg::SCORE_W-1])
      else $error("negative score without penalties");

endmodule

bind bisulfite_directional_hit_scorer_top bdhs_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_hit_score        (rsp_chan.hit_score),
   .rsp_bad_mismatches   (rsp_chan.bad_mismatches),
   .rsp_wrong_count      (rsp_chan.wrong_count),
   .rsp_noncounted_bases (rsp_chan.noncounted_bases)
);

@@ verif/hit_tally_pkg.sv @@
// Scoreboard for the hit scorer testbench: a bit-exact tally model that
// predicts one response per hit and checks the responses.
// Depends on bdhs_pkg for field widths, event codes and base letters.
`timescale 1ns / 1ps

package hit_tally_pkg;
   import bdhs_pkg::*;

   localparam int TALLY_BITS = COUNT_BITS_DEFAULT;
   localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;
   localparam logic [LEN_W-1:0] ONE_STEP = LEN_W'(1);
   localparam longint SCORE_HI = 2097151;
   localparam longint SCORE_LO = -2097152;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BASE_W-1:0] ref_base;
      logic [BASE_W-1:0] query_base;
      logic [LEN_W-1:0]  run_length;
      logic              last;
   } align_event_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] hit_score;
      logic [FIELD_W-1:0]        bad_mismatches;
      logic [FIELD_W-1:0]        conv_first;
      logic [FIELD_W-1:0]        unconv_first;
      logic [FIELD_W-1:0]        conv_second;
      logic [FIELD_W-1:0]        unconv_second;
      logic [FIELD_W-1:0]        wrong_count;
      logic [FIELD_W-1:0]        noncounted_bases;
   } hit_result_type;

   class hit_tally_predictor;
      bit orientation_one;
      logic [TALLY_BITS-1:0] match_n, expect_n, wrong_n, indel_n;
      logic [TALLY_BITS-1:0] conv_a_n, conv_b_n, unconv_a_n, unconv_b_n, noncount_n;
      hit_result_type expected_hits[$];
      int mismatch_count;

      function new();
         orientation_one = 1'b1;
         mismatch_count = 0;
         clear_tallies();
      endfunction

      function void clear_tallies();
         match_n = '0; expect_n = '0; wrong_n = '0; indel_n = '0;
         conv_a_n = '0; conv_b_n = '0; unconv_a_n = '0; unconv_b_n = '0;
         noncount_n = '0;
      endfunction

      // Add with saturation at the counter maximum
      function logic [TALLY_BITS-1:0] sat_add(logic [TALLY_BITS-1:0] c,
                                              logic [LEN_W-1:0] v);
         longint unsigned s;
         s = 64'(c) + 64'(v);
         return (s > 64'(TALLY_MAX)) ? TALLY_MAX : s[TALLY_BITS-1:0];
      endfunction

      // Tally one match column under the current orientation
      function void tally_column(logic [BASE_W-1:0] rb, logic [BASE_W-1:0] qb);
         logic [BASE_W-1:0] first, second, yield_first;
         bit is_conv;
         first  = orientation_one ? BASE_A : BASE_T;
         second = orientation_one ? BASE_C : BASE_G;
         yield_first = orientation_one ? BASE_G : BASE_A;
         if (rb == qb) begin
            match_n = sat_add(match_n, ONE_STEP);
            if (qb == first) unconv_a_n = sat_add(unconv_a_n, ONE_STEP);
            else if (qb == second) unconv_b_n = sat_add(unconv_b_n, ONE_STEP);
            return;
         end
         if (orientation_one)
            is_conv = (rb == BASE_C && qb == BASE_T) || (rb == BASE_A && qb == BASE_G);
         else
            is_conv = (rb == BASE_G && qb == BASE_A) || (rb == BASE_T && qb == BASE_C);
         if (is_conv) begin
            expect_n = sat_add(expect_n, ONE_STEP);
            if (qb == yield_first) conv_a_n = sat_add(conv_a_n, ONE_STEP);
            else conv_b_n = sat_add(conv_b_n, ONE_STEP);
         end else begin
            wrong_n = sat_add(wrong_n, ONE_STEP);
         end
      endfunction

      // Apply one accepted request; on last, queue the hit's response
      function void note_event(align_event_type ev);
         hit_result_type want;
         longint sc;
         case (ev.cmd)
            CMD_MATCH: tally_column(ev.ref_base, ev.query_base);
            CMD_INSERT, CMD_DELETE: begin
               noncount_n = sat_add(noncount_n, ev.run_length);
               indel_n = sat_add(indel_n, ev.run_length);
            end
            CMD_CLIP: noncount_n = sat_add(noncount_n, ev.run_length);
            default: ;
         endcase
         if (!ev.last) return;
         sc = match_n;
         sc = sc + expect_n;
         sc = sc - wrong_n;
         sc = sc - indel_n;
         if (sc > SCORE_HI) sc = SCORE_HI;
         if (sc < SCORE_LO) sc = SCORE_LO;
         want.hit_score        = sc[SCORE_W-1:0];
         want.bad_mismatches   = wrong_n;
         want.conv_first       = conv_a_n;
         want.unconv_first     = unconv_a_n;
         want.conv_second      = conv_b_n;
         want.unconv_second    = unconv_b_n;
         want.wrong_count      = wrong_n;
         want.noncounted_bases = noncount_n;
         expected_hits.push_back(want);
         clear_tallies();
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
      endtask

      // Check one accepted response against the oldest pending hit
      task check_hit(hit_result_type got);
         hit_result_type want;
         if (expected_hits.size() == 0) begin
            report_mismatch("response with no pending hit");
            return;
         end
         want = expected_hits.pop_front();
         compare_field("hit_score", got.hit_score, want.hit_score);
         compare_field("bad_mismatches", got.bad_mismatches, want.bad_mismatches);
         compare_field("conv_first", got.conv_first, want.conv_first);
         compare_field("unconv_first", got.unconv_first, want.unconv_first);
         compare_field("conv_second", got.conv_second, want.conv_second);
         compare_field("unconv_second", got.unconv_second, want.unconv_second);
         compare_field("wrong_count", got.wrong_count, want.wrong_count);
         compare_field("noncounted_bases", got.noncounted_bases, want.noncounted_bases);
      endtask
   endclass

endpackage

@@ verif/tb_top.sv @@
// Top of the hit scorer testbench: clock, reset, request and response drivers,
// directed and random alignment streams, and orientation changes between phases.
// Depends on bdhs_pkg, bdhs_if, the scorer top level and hit_tally_pkg.
`timescale 1ns / 1ps

module tb_top;
   import bdhs_pkg::*;
   import hit_tally_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_OFF     = 300;
   localparam int PHASE_ITEMS  = 250;
   localparam int IDLE_PCT     = 12;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   bdhs_req_if req_chan();
   bdhs_rsp_if rsp_chan();

   bit steady_mode;
   bit hold_off_req;
   int cycle_count;

   hit_tally_predictor tally = new();

   bisulfite_directional_hit_scorer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // End the run on a hang
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Note every accepted request in the tally model
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         tally.note_event({req_chan.cmd, req_chan.ref_base, req_chan.query_base,
                           req_chan.run_length, req_chan.last});
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tally.check_hit({rsp_chan.hit_score, rsp_chan.bad_mismatches,
                          rsp_chan.conv_first, rsp_chan.unconv_first,
                          rsp_chan.conv_second, rsp_chan.unconv_second,
                          rsp_chan.wrong_count, rsp_chan.noncounted_bases});
   end

   // Response side: random stalls, one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            for (int i = 0; i < HOLD_OFF; i++) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic align_event_type mk_event(logic [CMD_W-1:0] c, logic [BASE_W-1:0] rb,
                                                logic [BASE_W-1:0] qb, logic [LEN_W-1:0] len,
                                                logic last);
      align_event_type ev;
      ev.cmd = c; ev.ref_base = rb; ev.query_base = qb; ev.run_length = len; ev.last = last;
      return ev;
   endfunction

   // Mostly the four DNA letters, sometimes any byte
   function automatic logic [BASE_W-1:0] pick_base();
      int r;
      r = $urandom_range(99);
      if (r >= 85) return BASE_W'($urandom_range(255));
      case (r % 4)
         0: return BASE_A;
         1: return BASE_C;
         2: return BASE_G;
         default: return BASE_T;
      endcase
   endfunction

   // Mostly short runs, a few long ones
   function automatic logic [LEN_W-1:0] pick_run();
      int r;
      r = $urandom_range(99);
      if (r < 90) return LEN_W'($urandom_range(40));
      if (r < 98) return LEN_W'($urandom_range(65535));
      return LEN_W'($urandom);
   endfunction

   // One event of a well-formed hit
   function automatic align_event_type pick_event(logic last);
      align_event_type ev;
      int r;
      r = $urandom_range(99);
      ev.ref_base = pick_base();
      ev.query_base = $urandom_range(1) ? ev.ref_base : pick_base();
      ev.run_length = pick_run();
      ev.last = last;
      if (r < 70) ev.cmd = CMD_MATCH;
      else if (r < 78) ev.cmd = CMD_INSERT;
      else if (r < 86) ev.cmd = CMD_CLIP;
      else if (r < 93) ev.cmd = CMD_DELETE;
      else if (r < 97) ev.cmd = CMD_SKIP;
      else ev.cmd = CMD_W'($urandom_range(CMD_IGNORE, 7));
      return ev;
   endfunction

   // Offer one request and hold it until it is taken
   task automatic send_event(input align_event_type ev);
      if (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= ev.cmd;
      req_chan.ref_base   <= ev.ref_base;
      req_chan.query_base <= ev.query_base;
      req_chan.run_length <= ev.run_length;
      req_chan.last       <= ev.last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every pending hit has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (tally.expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_orientation(input bit ori);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ori;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tally.orientation_one = ori;
   endtask

   // Random hits with some noise and some hits missing their last flag
   task automatic run_hits(input int n_items);
      align_event_type ev;
      int sent;
      int n_ev;
      bit drop_last;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 10) begin
            ev = mk_event(CMD_W'($urandom_range(7)), BASE_W'($urandom_range(255)),
                          BASE_W'($urandom_range(255)), LEN_W'($urandom),
                          $urandom_range(7) == 0);
            send_event(ev);
            sent++;
         end else begin
            n_ev = $urandom_range(1, 12);
            drop_last = $urandom_range(99) < 5;
            for (int e = 0; e < n_ev; e++) begin
               ev = pick_event(e == n_ev - 1 && !drop_last);
               send_event(ev);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      req_chan.valid      <= 1'b0;
      req_chan.cmd        <= CMD_IGNORE;
      req_chan.ref_base   <= '0;
      req_chan.query_base <= '0;
      req_chan.run_length <= '0;
      req_chan.last       <= 1'b0;
      steady_mode  = 1'b0;
      hold_off_req = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed hits under the reset orientation
      send_event(mk_event(CMD_MATCH, BASE_A, BASE_A, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_C, BASE_C, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_G, BASE_G, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_T, BASE_T, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_C, BASE_T, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_A, BASE_G, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_G, BASE_A, 0, 0));
      send_event(mk_event(CMD_MATCH, 8'h00, 8'hFF, 0, 0));
      send_event(mk_event(CMD_MATCH, 8'hFF, 8'hFF, 0, 0));
      // lowercase reference base never equals an uppercase query
      send_event(mk_event(CMD_MATCH, 8'h61, BASE_A, 0, 0));
      // run length on a match column still counts once
      send_event(mk_event(CMD_MATCH, BASE_A, BASE_A, '1, 0));
      send_event(mk_event(CMD_INSERT, 0, 0, 5, 0));
      send_event(mk_event(CMD_CLIP, 0, 0, 7, 0));
      send_event(mk_event(CMD_DELETE, 0, 0, 3, 0));
      send_event(mk_event(CMD_SKIP, 8'hFF, 8'hFF, '1, 0));
      send_event(mk_event(CMD_IGNORE, 8'hFF, 8'hFF, '1, 0));
      send_event(mk_event(3'd6, BASE_A, BASE_A, 9, 0));
      send_event(mk_event(3'd7, BASE_C, BASE_C, 9, 1));
      // saturate the indel and non-counted totals
      send_event(mk_event(CMD_DELETE, 0, 0, '1, 0));
      send_event(mk_event(CMD_INSERT, 0, 0, '1, 1));
      send_event(mk_event(CMD_MATCH, BASE_C, BASE_C, 0, 1));
      send_event(mk_event(CMD_SKIP, 0, 0, 0, 1));
      send_event(mk_event(CMD_CLIP, 0, 0, 0, 1));

      // Directed hit under the other orientation
      set_orientation(1'b0);
      send_event(mk_event(CMD_MATCH, BASE_T, BASE_T, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_G, BASE_G, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_G, BASE_A, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_T, BASE_C, 0, 0));
      send_event(mk_event(CMD_MATCH, BASE_C, BASE_T, 0, 1));

      // Random phases, alternating orientation
      set_orientation(1'b1);
      run_hits(PHASE_ITEMS);
      set_orientation(1'b0);
      steady_mode = 1'b1;
      run_hits(PHASE_ITEMS);
      steady_mode = 1'b0;
      set_orientation(1'b1);
      hold_off_req = 1'b1;
      run_hits(PHASE_ITEMS);
      set_orientation(1'b0);
      run_hits(PHASE_ITEMS);
      set_orientation(1'b1);
      run_hits(PHASE_ITEMS);

      drain();
      if (tally.mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
